/* design/bpe_pkg.sv */
// ----------------------------------------------------------------------------
// bpe_pkg
// Shared types and constants for the bitmap paint engine: item structs,
// command codes, internal operation codes and the controller state type.
// ----------------------------------------------------------------------------
package bpe_pkg;

  // Bitmap geometry.
  localparam int MAX_ROWS = 128;
  localparam int MAX_COLS = 128;
  localparam int ROW_AW   = $clog2(MAX_ROWS);
  localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  // Signed coordinate width: holds a centre plus or minus a half size and the limits.
  localparam int CRD_W    = $clog2(MAX_DIM) + 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 1'b1;
  localparam logic [CFG_DATA_W-1:0] ROWS_USED_RST = 8'd128;
  localparam logic [CFG_DATA_W-1:0] COLS_USED_RST = 8'd128;

  // Command codes carried in the func field.
  typedef enum logic [2:0] {
    FN_NOP       = 3'd0,
    FN_PAINT_SQ  = 3'd1,
    FN_PAINT_LN  = 3'd2,
    FN_ERASE     = 3'd3,
    FN_READ      = 3'd4,
    FN_CLEAR     = 3'd5
  } func_t;

  // Internal operation after decode.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_PAINT,
    OP_ERASE,
    OP_READ,
    OP_CLEAR
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Input request.
  typedef struct packed {
    logic [2:0] func;
    logic [6:0] row_a;
    logic [6:0] col_a;
    logic [6:0] row_b;
    logic [6:0] col_b;
    logic [5:0] half_size;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic status;
    logic cell_value;
  } out_item_t;

  // Decoded command: operation and unclipped rectangle.
  typedef struct packed {
    op_t                     op;
    logic                    status;
    logic signed [CRD_W-1:0] rlo;
    logic signed [CRD_W-1:0] rhi;
    logic signed [CRD_W-1:0] clo;
    logic signed [CRD_W-1:0] chi;
  } plan_t;

  // Row memory access controls.
  typedef struct packed {
    logic              rd_en;
    logic [ROW_AW-1:0] rd_addr;
    logic              wr_en;
    logic [ROW_AW-1:0] wr_addr;
    logic              clear;
  } mem_req_t;

endpackage

/* design/bitmap_paint_engine.sv */
// ----------------------------------------------------------------------------
// bitmap_paint_engine
// One-bit bitmap with square, line, erase, read and clear commands; each
// request returns a status and the bit that a read request found.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake         Payload
//   in_      input      in_valid/in_stall in_data (bpe_pkg::in_item_t)
//   out_     output     out_valid/stall   out_data (bpe_pkg::out_item_t)
//   cfg_     input      cfg_valid/ready   cfg_index, cfg_data (8 bits)
//
// A request that touches n clipped rows (1 for erase or read, up to 127 for a
// square and 128 for a vertical line) passes through one setup step, a walk of
// one row per cycle through the row memory's read and write ports, one drain
// step and one result step. Nop, clear and requests with no row inside the area
// skip the walk. The next request is accepted in the cycle after the result is
// loaded.
// Reset clears the row valid bits at once; the block is ready right away.
// A stalled result waits in the output register while the next request runs.
// ----------------------------------------------------------------------------
module bitmap_paint_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bpe_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bpe_pkg::out_item_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bpe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpe_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [bpe_pkg::CFG_DATA_W-1:0] rows_used_r, cols_used_r;
  bpe_pkg::plan_t                 plan;
  bpe_pkg::mem_req_t              mem_req;
  logic [bpe_pkg::MAX_COLS-1:0]   mem_wr_data, mem_rd_data;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= bpe_pkg::ROWS_USED_RST;
      cols_used_r <= bpe_pkg::COLS_USED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpe_pkg::CFG_ROWS_USED: rows_used_r <= cfg_data;
        bpe_pkg::CFG_COLS_USED: cols_used_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Command decode.
  bpe_cmd_dec u_dec (
    .item (in_data),
    .plan (plan)
  );

  // Sequencer.
  bpe_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .rows_used   (rows_used_r),
    .cols_used   (cols_used_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .plan_in     (plan),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mem_req     (mem_req),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data)
  );

  // Bitmap rows.
  bpe_row_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

endmodule

/* design/bpe_row_mem.sv */
// ----------------------------------------------------------------------------
// bpe_row_mem
// Bitmap storage: one row of cells per entry, one write and one registered
// read per cycle, and one valid bit per row so a clear resets every row at once.
// ----------------------------------------------------------------------------
module bpe_row_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bpe_pkg::mem_req_t            req,
  input  logic [bpe_pkg::MAX_COLS-1:0] wr_data,
  output logic [bpe_pkg::MAX_COLS-1:0] rd_data
);

  logic [bpe_pkg::MAX_COLS-1:0] mem [bpe_pkg::MAX_ROWS];
  logic [bpe_pkg::MAX_COLS-1:0] q_r;
  logic [bpe_pkg::MAX_ROWS-1:0] valid_r;
  logic                         rd_vld_r;

  // Row array: write port and registered read port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      q_r <= mem[req.rd_addr];
    end
  end

  // Row valid bits: cleared by reset or a clear request, set on a write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.clear) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= valid_r[req.rd_addr];
      end
    end
  end

  // A row never written since the last clear reads as all zeros.
  assign rd_data = rd_vld_r ? q_r : '0;

endmodule

/* design/bpe_cmd_dec.sv */
// ----------------------------------------------------------------------------
// bpe_cmd_dec
// Command decoder: turns a request into an operation, a status and the
// unclipped row and column range that the operation covers.
// ----------------------------------------------------------------------------
module bpe_cmd_dec (
  input  bpe_pkg::in_item_t item,
  output bpe_pkg::plan_t    plan
);

  logic signed [bpe_pkg::CRD_W-1:0] ra, ca, rb, cb, hs;

  // Widen the coordinates to the signed working width.
  always_comb begin
    ra = bpe_pkg::CRD_W'(item.row_a);
    ca = bpe_pkg::CRD_W'(item.col_a);
    rb = bpe_pkg::CRD_W'(item.row_b);
    cb = bpe_pkg::CRD_W'(item.col_b);
    hs = bpe_pkg::CRD_W'(item.half_size);
  end

  // Select the operation and its rectangle.
  always_comb begin
    plan.op     = bpe_pkg::OP_NOP;
    plan.status = 1'b0;
    plan.rlo    = ra;
    plan.rhi    = ra;
    plan.clo    = ca;
    plan.chi    = ca;
    case (item.func)
      bpe_pkg::FN_PAINT_SQ: begin
        plan.op  = bpe_pkg::OP_PAINT;
        plan.rlo = ra - hs;
        plan.rhi = ra + hs;
        plan.clo = ca - hs;
        plan.chi = ca + hs;
      end
      bpe_pkg::FN_PAINT_LN: begin
        if (ca == cb) begin
          // Vertical line, drawn only top to bottom.
          if (ra <= rb) begin
            plan.op  = bpe_pkg::OP_PAINT;
            plan.rhi = rb;
          end else begin
            plan.status = 1'b1;
          end
        end else if (ra == rb) begin
          // Horizontal line, drawn only left to right.
          if (ca <= cb) begin
            plan.op  = bpe_pkg::OP_PAINT;
            plan.chi = cb;
          end else begin
            plan.status = 1'b1;
          end
        end else begin
          plan.status = 1'b1;
        end
      end
      bpe_pkg::FN_ERASE: begin
        plan.op = bpe_pkg::OP_ERASE;
      end
      bpe_pkg::FN_READ: begin
        plan.op = bpe_pkg::OP_READ;
      end
      bpe_pkg::FN_CLEAR: begin
        plan.op = bpe_pkg::OP_CLEAR;
      end
      default: begin
        plan.status = 1'b1;
      end
    endcase
  end

endmodule

/* design/bpe_ctrl.sv */
// ----------------------------------------------------------------------------
// bpe_ctrl
// Command sequencer: clips the rectangle to the area in use, builds the column
// mask, walks the rows (a pipelined read-modify-write of the memory for paint
// and erase, a read for read) and hands the result to the output register.
// ----------------------------------------------------------------------------
module bpe_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bpe_pkg::CFG_DATA_W-1:0] rows_used,
  input  logic [bpe_pkg::CFG_DATA_W-1:0] cols_used,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bpe_pkg::plan_t               plan_in,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bpe_pkg::out_item_t           out_data,
  output bpe_pkg::mem_req_t            mem_req,
  output logic [bpe_pkg::MAX_COLS-1:0] mem_wr_data,
  input  logic [bpe_pkg::MAX_COLS-1:0] mem_rd_data
);

  bpe_pkg::state_t              state_r, state_nxt;
  bpe_pkg::plan_t               plan_r;
  logic [bpe_pkg::MAX_COLS-1:0] mask_r;
  logic [bpe_pkg::ROW_AW-1:0]   row_r, row_end_r, wb_row_r;
  logic                         wb_pend_r, wb_pend_nxt;
  logic                         val_r;
  logic                         out_valid_r;
  bpe_pkg::out_item_t           out_r;

  logic                             accept;
  logic                             slot_free;
  logic                             load_out;
  logic signed [bpe_pkg::CRD_W-1:0] rows_lim, cols_lim;
  logic signed [bpe_pkg::CRD_W-1:0] rlo_c, rhi_c;
  logic                             rows_empty;
  logic [bpe_pkg::MAX_COLS-1:0]     mask_set;
  logic signed [bpe_pkg::CRD_W-1:0] jc;

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  // Clip the row range to the rows in use.
  always_comb begin
    rows_lim = bpe_pkg::CRD_W'(rows_used);
    if (rows_lim > bpe_pkg::CRD_W'(bpe_pkg::MAX_ROWS)) begin
      rows_lim = bpe_pkg::CRD_W'(bpe_pkg::MAX_ROWS);
    end
    cols_lim = bpe_pkg::CRD_W'(cols_used);
    if (cols_lim > bpe_pkg::CRD_W'(bpe_pkg::MAX_COLS)) begin
      cols_lim = bpe_pkg::CRD_W'(bpe_pkg::MAX_COLS);
    end
    rlo_c = (plan_r.rlo < 0) ? '0 : plan_r.rlo;
    rhi_c = (plan_r.rhi > rows_lim - bpe_pkg::CRD_W'(1)) ? rows_lim - bpe_pkg::CRD_W'(1)
                                                         : plan_r.rhi;
    rows_empty = rlo_c > rhi_c;
  end

  // Column mask: three compares per column.
  always_comb begin
    jc = '0;
    for (int j = 0; j < bpe_pkg::MAX_COLS; j++) begin
      jc = bpe_pkg::CRD_W'(j);
      mask_set[j] = (jc >= plan_r.clo) && (jc <= plan_r.chi) && (jc < cols_lim);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bpe_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = bpe_pkg::ST_SETUP;
        end
      end
      bpe_pkg::ST_SETUP: begin
        if ((plan_r.op == bpe_pkg::OP_PAINT || plan_r.op == bpe_pkg::OP_ERASE ||
             plan_r.op == bpe_pkg::OP_READ) && !rows_empty) begin
          state_nxt = bpe_pkg::ST_RUN;
        end else begin
          state_nxt = bpe_pkg::ST_FINISH;
        end
      end
      bpe_pkg::ST_RUN: begin
        if (row_r == row_end_r) begin
          state_nxt = bpe_pkg::ST_DRAIN;
        end
      end
      bpe_pkg::ST_DRAIN: begin
        state_nxt = bpe_pkg::ST_FINISH;
      end
      bpe_pkg::ST_FINISH: begin
        if (slot_free) begin
          state_nxt = bpe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bpe_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs: memory controls, handshake and output load.
  always_comb begin
    in_stall        = (state_r != bpe_pkg::ST_IDLE);
    mem_req.rd_en   = (state_r == bpe_pkg::ST_RUN);
    mem_req.rd_addr = row_r;
    mem_req.wr_en   = wb_pend_r && (plan_r.op != bpe_pkg::OP_READ);
    mem_req.wr_addr = wb_row_r;
    mem_req.clear   = (state_r == bpe_pkg::ST_SETUP) && (plan_r.op == bpe_pkg::OP_CLEAR);
    wb_pend_nxt     = (state_r == bpe_pkg::ST_RUN);
    load_out        = (state_r == bpe_pkg::ST_FINISH) && slot_free;
  end

  // Modify step: paint sets the masked cells, erase clears them.
  assign mem_wr_data = (plan_r.op == bpe_pkg::OP_PAINT) ? (mem_rd_data | mask_r)
                                                         : (mem_rd_data & ~mask_r);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpe_pkg::ST_IDLE;
      wb_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wb_pend_r <= wb_pend_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      plan_r <= plan_in;
    end
    if (state_r == bpe_pkg::ST_SETUP) begin
      mask_r    <= mask_set;
      row_r     <= rlo_c[bpe_pkg::ROW_AW-1:0];
      row_end_r <= rhi_c[bpe_pkg::ROW_AW-1:0];
      val_r     <= 1'b0;
    end else if (state_r == bpe_pkg::ST_RUN) begin
      row_r <= row_r + 1'b1;
    end
    wb_row_r <= row_r;
    // A read request picks its cell out of the returned row.
    if (state_r == bpe_pkg::ST_DRAIN && plan_r.op == bpe_pkg::OP_READ) begin
      val_r <= |(mem_rd_data & mask_r);
    end
    if (load_out) begin
      out_r.status     <= plan_r.status;
      out_r.cell_value <= val_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The row walk never passes the clipped last row.
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == bpe_pkg::ST_RUN |-> row_r <= row_end_r)
    else $error("row walk passed its last row");

  // The write-back and the next read never touch the same row.
  a_no_same_row: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_addr != mem_req.rd_addr)
    else $error("read and write of the same row in one cycle");

  // A read request never writes the bitmap.
  a_read_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    plan_r.op == bpe_pkg::OP_READ && state_r != bpe_pkg::ST_IDLE |-> !mem_req.wr_en)
    else $error("read request wrote the bitmap");

  // A finished request is presented in the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result not presented");

  // Every write-back follows a read of the same row in the previous cycle.
  a_wb_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> $past(mem_req.rd_en) && $past(mem_req.rd_addr) == mem_req.wr_addr)
    else $error("write-back without matching read");

endmodule
